FILE: rtl/gfhc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gfhc_pkg: shared types and constants of the heat field colorizer
// Fixed-point formats, payload words, pipeline words, register map and the
// falloff table that the exp stage interpolates.
// ---------------------------------------------------------------------------
package gfhc_pkg;

   // Q1.12 values carry one integer bit so that 1.0 is representable
   localparam int FRAC_BITS = 12;
   localparam int VAL_W     = FRAC_BITS + 1;
   localparam int SQ_W      = 2 * VAL_W;          // one squared difference
   localparam int D2_W      = SQ_W + 2;           // sum of three squares
   localparam int QUOT_W    = 16;                 // u = d2 / r2 in Q.12, below 16.0
   localparam int REM_W     = 42;                 // d2 << 12 while below 16 * r2
   localparam int EXP_DEPTH = 256;
   localparam int EXP_W     = 33;                 // Q.32 with room for 1.0

   localparam logic [VAL_W-1:0] LEVEL_ONE  = VAL_W'(1 << FRAC_BITS);
   localparam logic [VAL_W-1:0] RADIUS_MIN = VAL_W'(123);

   // register map
   localparam logic [2:0] REG_FIELD_MODE     = 3'd0;
   localparam logic [2:0] REG_SOURCE_X       = 3'd1;
   localparam logic [2:0] REG_SOURCE_Y       = 3'd2;
   localparam logic [2:0] REG_SOURCE_Z       = 3'd3;
   localparam logic [2:0] REG_FALLOFF_RADIUS = 3'd4;
   localparam logic [2:0] REG_GAIN           = 3'd5;
   localparam logic [2:0] REG_SHOW_THRESHOLD = 3'd6;

   typedef struct packed {
      logic [VAL_W-1:0] point_x;
      logic [VAL_W-1:0] point_y;
      logic [VAL_W-1:0] point_z;
   } point_type;

   typedef struct packed {
      logic [VAL_W-1:0] field_level;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic             visible;
   } result_type;

   // settings seen by the pipeline; the user must keep them static while points are in flight
   typedef struct packed {
      logic             field_mode;
      logic [VAL_W-1:0] source_x;
      logic [VAL_W-1:0] source_y;
      logic [VAL_W-1:0] source_z;
      logic [SQ_W-1:0]  r2;
      logic [VAL_W-1:0] gain;
      logic [VAL_W-1:0] show_threshold;
   } field_cfg_type;

   // one step of the quotient pipeline
   typedef struct packed {
      logic              valid;
      logic              far;
      logic [REM_W-1:0]  rem;
      logic [QUOT_W-1:0] quot;
   } div_word_type;

   typedef struct packed {
      logic             valid;
      logic [VAL_W-1:0] level;
      logic             visible;
   } level_word_type;

   typedef logic [EXP_W-1:0] exp_tab_type [0:EXP_DEPTH];

   // shift-and-subtract quotient, evaluated only while building the table
   function automatic logic [63:0] quotient64(input logic [63:0] num,
                                              input logic [63:0] den);
      logic [63:0] rem;
      logic [63:0] quo;
      rem = 64'd0;
      quo = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(-16*i/256) in Q.32: one Taylor step, then repeated rounded products
   function automatic exp_tab_type exp_table();
      logic [63:0] term;
      logic [63:0] plus;
      logic [63:0] minus;
      logic [63:0] q;
      logic [63:0] acc;
      exp_tab_type tab;
      term  = 64'd1 << 32;
      plus  = 64'd1 << 32;
      minus = 64'd0;
      for (int n = 1; n <= 24; n++) begin
         term = quotient64(term * 64'd16, 64'(EXP_DEPTH) * 64'(n));
         if (n[0]) begin
            minus = minus + term;
         end else begin
            plus = plus + term;
         end
      end
      q      = plus - minus;
      acc    = 64'd1 << 32;
      tab[0] = EXP_W'(acc);
      for (int i = 1; i <= EXP_DEPTH; i++) begin
         acc    = (acc * q + (64'd1 << 31)) >> 32;
         tab[i] = EXP_W'(acc);
      end
      return tab;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/gfhc_dist.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gfhc_dist: squared distance front end
// Four stages: differences, squares, sums and sweep scaling, mode select with
// the far-field test that seeds the quotient pipeline.
// ---------------------------------------------------------------------------
module gfhc_dist (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire gfhc_pkg::point_type     point,
   input  wire gfhc_pkg::field_cfg_type cfg,
   output gfhc_pkg::div_word_type       div_out
);
   localparam int VW = gfhc_pkg::VAL_W;
   localparam int SW = gfhc_pkg::SQ_W;
   localparam int DW = gfhc_pkg::D2_W;
   localparam int RW = gfhc_pkg::REM_W;
   // floor(x/5) = (x * ceil(2^30/5)) >> 30 for x below 2^30
   localparam logic [27:0] RECIP5 = 28'd214748365;

   logic          v1_ff, v2_ff, v3_ff;
   logic [VW-1:0] dx1_ff, dy1_ff, dz1_ff;
   logic [SW-1:0] sx2_ff, sy2_ff, sz2_ff;
   logic [SW-1:0] sx3_ff;
   logic [DW-1:0] sum3_ff;
   logic [53:0]   dyp3_ff;
   logic [DW-1:0] d2_in;
   logic          far_in;
   gfhc_pkg::div_word_type div_ff;

   function automatic logic [VW-1:0] absdiff(input logic [VW-1:0] a, input logic [VW-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // pick the distance for the mode and test against 16 * r2
   always_comb begin
      if (cfg.field_mode) begin
         d2_in = DW'(sx3_ff) + DW'(dyp3_ff[53:30]);
      end else begin
         d2_in = sum3_ff;
      end
      far_in = ({2'b00, d2_in} >= {cfg.r2, 4'b0000});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         div_ff.valid  <= 1'b0;
      end else begin
         v1_ff         <= in_valid;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         div_ff.valid  <= v3_ff;
      end
      // stage 1: absolute differences
      dx1_ff  <= absdiff(point.point_x, cfg.source_x);
      dy1_ff  <= absdiff(point.point_y, cfg.source_y);
      dz1_ff  <= absdiff(point.point_z, cfg.source_z);
      // stage 2: squares
      sx2_ff  <= SW'(dx1_ff * dx1_ff);
      sy2_ff  <= SW'(dy1_ff * dy1_ff);
      sz2_ff  <= SW'(dz1_ff * dz1_ff);
      // stage 3: radial sum and the dy^2/5 product
      sum3_ff <= DW'(sx2_ff) + DW'(sy2_ff) + DW'(sz2_ff);
      sx3_ff  <= sx2_ff;
      dyp3_ff <= 54'(sy2_ff) * 54'(RECIP5);
      // stage 4: seed the divider, empty remainder when the field is gone
      div_ff.far  <= far_in;
      div_ff.rem  <= far_in ? '0 : RW'({d2_in, 12'b0});
      div_ff.quot <= '0;
   end

   assign div_out = div_ff;

endmodule
`default_nettype wire

FILE: rtl/gfhc_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gfhc_div: pipelined restoring divider
// Sixteen stages, one quotient bit each, form u = (d2 << 12) / r2.
// ---------------------------------------------------------------------------
module gfhc_div (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire gfhc_pkg::div_word_type div_in,
   input  wire logic [gfhc_pkg::SQ_W-1:0] r2,
   output gfhc_pkg::div_word_type      div_out
);
   localparam int STEPS = gfhc_pkg::QUOT_W;
   localparam int RW    = gfhc_pkg::REM_W;

   gfhc_pkg::div_word_type step_src [0:STEPS-1];
   gfhc_pkg::div_word_type stage_ff [0:STEPS-1];

   assign step_src[0] = div_in;

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      localparam int K = STEPS - 1 - j;
      logic [RW-1:0]    sub;
      logic             ge;
      logic [STEPS-1:0] quot_in;

      if (j > 0) begin : g_link
         assign step_src[j] = stage_ff[j-1];
      end

      // try the divisor at this bit weight
      assign sub     = RW'(r2) << K;
      assign ge      = step_src[j].rem >= sub;
      assign quot_in = step_src[j].quot | (STEPS'(ge) << K);

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[j].valid <= 1'b0;
         end else begin
            stage_ff[j].valid <= step_src[j].valid;
         end
         stage_ff[j].far  <= step_src[j].far;
         stage_ff[j].rem  <= ge ? step_src[j].rem - sub : step_src[j].rem;
         stage_ff[j].quot <= quot_in;
      end
   end

   assign div_out = stage_ff[STEPS-1];

endmodule
`default_nettype wire

FILE: rtl/gfhc_exp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gfhc_exp: falloff lookup and gain
// Interpolates exp(-u) from the table, scales by gain, rounds, clamps to one
// and compares with the show threshold. Five stages.
// ---------------------------------------------------------------------------
module gfhc_exp (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire gfhc_pkg::div_word_type  div_in,
   input  wire gfhc_pkg::field_cfg_type cfg,
   output gfhc_pkg::level_word_type     level_out
);
   localparam int EW = gfhc_pkg::EXP_W;
   localparam int VW = gfhc_pkg::VAL_W;
   localparam gfhc_pkg::exp_tab_type EXP_TAB = gfhc_pkg::exp_table();

   logic          v1_ff, v2_ff, v3_ff, v4_ff;
   logic          far1_ff, far2_ff;
   logic [EW-1:0] t0_1_ff, t0_2_ff;
   logic [EW-1:0] diff1_ff;
   logic [11:0]   fr1_ff;
   logic [44:0]   prod2_ff;
   logic [EW-1:0] e3_ff;
   logic [46:0]   pg4_ff;
   logic [8:0]    idx0, idx1;
   logic [EW-1:0] t0, t1;
   logic [14:0]   raw_level;
   logic [VW-1:0] level_in;
   gfhc_pkg::level_word_type out_ff;

   // table pair around u * 16
   assign idx0 = {1'b0, div_in.quot[15:8]};
   assign idx1 = idx0 + 9'd1;
   assign t0   = EXP_TAB[idx0];
   assign t1   = EXP_TAB[idx1];

   // round, then clamp to one
   assign raw_level = pg4_ff[46:32];
   assign level_in  = (raw_level > 15'(gfhc_pkg::LEVEL_ONE)) ? gfhc_pkg::LEVEL_ONE
                                                           : VW'(raw_level);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         v1_ff        <= div_in.valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         out_ff.valid <= v4_ff;
      end
      t0_1_ff  <= t0;
      diff1_ff <= t0 - t1;
      fr1_ff   <= {div_in.quot[7:0], 4'b0000};
      far1_ff  <= div_in.far;
      prod2_ff <= 45'(diff1_ff) * 45'(fr1_ff);
      t0_2_ff  <= t0_1_ff;
      far2_ff  <= far1_ff;
      e3_ff    <= far2_ff ? '0 : t0_2_ff - prod2_ff[44:12];
      pg4_ff   <= 47'(cfg.gain) * 47'(e3_ff) + (47'd1 << 31);
      out_ff.level   <= level_in;
      out_ff.visible <= level_in >= cfg.show_threshold;
   end

   assign level_out = out_ff;

endmodule
`default_nettype wire

FILE: rtl/gfhc_ramp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gfhc_ramp: fire color ramp
// Picks one of four segments, forms the scaled numerators, then divides by
// the segment span with reciprocal products. Two stages.
// ---------------------------------------------------------------------------
module gfhc_ramp (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire gfhc_pkg::level_word_type level_in,
   output logic                          out_valid,
   output gfhc_pkg::result_type          result
);
   localparam int VW = gfhc_pkg::VAL_W;

   typedef enum logic [1:0] {SEG_DARK, SEG_RISE, SEG_WARM, SEG_HOT} seg_type;

   logic [18:0] s;
   logic [16:0] d_rise, d_warm, d_hot;
   seg_type     seg_in;
   logic [24:0] nr_in, ng_in, nb_in;
   logic [7:0]  b_dark_in;

   logic          v1_ff, v2_ff;
   seg_type       seg_ff;
   logic [24:0]   nr_ff, ng_ff, nb_ff;
   logic [7:0]    b_dark_ff;
   logic [VW-1:0] level_ff;
   logic          visible_ff;
   logic [7:0]    red_in, green_in, blue_in;
   gfhc_pkg::result_type result_ff;

   // floor(n / (30 * 4096)) by way of floor(n / 4096) * ceil(2^18 / 30)
   function automatic logic [7:0] div30(input logic [24:0] n);
      logic [26:0] p;
      p = 27'(n[24:12]) * 27'd8739;
      return 8'(p >> 18);
   endfunction

   // floor(n / (25 * 4096)) the same way
   function automatic logic [7:0] div25(input logic [24:0] n);
      logic [26:0] p;
      p = 27'(n[24:12]) * 27'd10486;
      return 8'(p >> 18);
   endfunction

   // segment choice and numerators
   always_comb begin
      s         = 19'(32'(level_in.level) * 100);
      d_rise    = 17'(s - 19'd61440);
      d_warm    = 17'(s - 19'd184320);
      d_hot     = (s - 19'd307200 > 19'd102400) ? 17'd102400 : 17'(s - 19'd307200);
      b_dark_in = 8'(20 + ((32'(level_in.level) * 400) >> 12));
      nr_in     = '0;
      ng_in     = '0;
      nb_in     = '0;
      if (s < 19'd61440) begin
         seg_in = SEG_DARK;
      end else if (s < 19'd184320) begin
         seg_in = SEG_RISE;
         nr_in  = 25'(32'(d_rise) * 242);
         ng_in  = 25'(32'(d_rise) * 51);
         nb_in  = 25'(32'(d_rise) * 71 + 122879);
      end else if (s < 19'd307200) begin
         seg_in = SEG_WARM;
         ng_in  = 25'(32'(d_warm) * 166);
         nb_in  = 25'(32'(d_warm) * 13 + 122879);
      end else begin
         seg_in = SEG_HOT;
         ng_in  = 25'(32'(d_hot) * 217 + 102399);
      end
   end

   // finish the channels
   always_comb begin
      red_in   = 8'd0;
      green_in = 8'd0;
      blue_in  = 8'd0;
      case (seg_ff)
         SEG_DARK: begin
            blue_in = b_dark_ff;
         end
         SEG_RISE: begin
            red_in   = div30(nr_ff);
            green_in = div30(ng_ff);
            blue_in  = 8'd84 - div30(nb_ff);
         end
         SEG_WARM: begin
            red_in   = 8'd242;
            green_in = 8'd51 + div30(ng_ff);
            blue_in  = 8'd13 - div30(nb_ff);
         end
         SEG_HOT: begin
            red_in   = 8'd255;
            green_in = 8'd217 - div25(ng_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= level_in.valid;
         v2_ff <= v1_ff;
      end
      seg_ff     <= seg_in;
      nr_ff      <= nr_in;
      ng_ff      <= ng_in;
      nb_ff      <= nb_in;
      b_dark_ff  <= b_dark_in;
      level_ff   <= level_in.level;
      visible_ff <= level_in.visible;
      result_ff.field_level <= level_ff;
      result_ff.red         <= red_in;
      result_ff.green       <= green_in;
      result_ff.blue        <= blue_in;
      result_ff.visible     <= visible_ff;
   end

   assign out_valid = v2_ff;
   assign result    = result_ff;

endmodule
`default_nettype wire

FILE: rtl/gaussian_field_heat_color.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gaussian_field_heat_color: Gaussian heat field with fire color output
// Evaluates gain * exp(-d2 / r^2) at each point and maps it to RGB.
// ---------------------------------------------------------------------------
// One point enters per clock; busy never rises, so start may be held high
// every cycle. Each point gives one word on rsp_result, flagged by rsp_valid
// for a single cycle, in order. The receiver must take it then: there is no
// back-pressure. Each point passes four distance stages, the sixteen-stage
// quotient divider, five exp stages and two color stages. Write registers
// through csr_* only while no point is in flight.
module gaussian_field_heat_color (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire gfhc_pkg::point_type          req_point,
   output logic                              rsp_valid,
   output gfhc_pkg::result_type              rsp_result,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [2:0]                   csr_index,
   input  wire logic [gfhc_pkg::VAL_W-1:0]   csr_wdata
);
   localparam int VW = gfhc_pkg::VAL_W;

   logic          field_mode_ff;
   logic [VW-1:0] source_x_ff, source_y_ff, source_z_ff;
   logic [VW-1:0] radius_ff, gain_ff, threshold_ff;
   logic [VW-1:0] rad;
   logic [gfhc_pkg::SQ_W-1:0] r2_ff;
   gfhc_pkg::field_cfg_type   cfg;
   gfhc_pkg::div_word_type    div_head, div_tail;
   gfhc_pkg::level_word_type  level_word;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         field_mode_ff <= 1'b0;
         source_x_ff   <= VW'(2048);
         source_y_ff   <= VW'(2048);
         source_z_ff   <= VW'(2048);
         radius_ff     <= VW'(1434);
         gain_ff       <= VW'(4915);
         threshold_ff  <= VW'(123);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            gfhc_pkg::REG_FIELD_MODE:     field_mode_ff <= csr_wdata[0];
            gfhc_pkg::REG_SOURCE_X:       source_x_ff   <= csr_wdata;
            gfhc_pkg::REG_SOURCE_Y:       source_y_ff   <= csr_wdata;
            gfhc_pkg::REG_SOURCE_Z:       source_z_ff   <= csr_wdata;
            gfhc_pkg::REG_FALLOFF_RADIUS: radius_ff     <= csr_wdata;
            gfhc_pkg::REG_GAIN:           gain_ff       <= csr_wdata;
            gfhc_pkg::REG_SHOW_THRESHOLD: threshold_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // saturate a tiny radius, keep r^2 ready for the divider
   assign rad = (radius_ff < gfhc_pkg::RADIUS_MIN) ? gfhc_pkg::RADIUS_MIN : radius_ff;

   always_ff @(posedge clock) begin
      r2_ff <= gfhc_pkg::SQ_W'(rad * rad);
   end

   always_comb begin
      cfg.field_mode     = field_mode_ff;
      cfg.source_x       = source_x_ff;
      cfg.source_y       = source_y_ff;
      cfg.source_z       = source_z_ff;
      cfg.r2             = r2_ff;
      cfg.gain           = gain_ff;
      cfg.show_threshold = threshold_ff;
   end

   gfhc_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .point    (req_point),
      .cfg      (cfg),
      .div_out  (div_head)
   );

   gfhc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_in  (div_head),
      .r2      (r2_ff),
      .div_out (div_tail)
   );

   gfhc_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .div_in    (div_tail),
      .cfg       (cfg),
      .level_out (level_word)
   );

   gfhc_ramp u_ramp (
      .clock     (clock),
      .reset     (reset),
      .level_in  (level_word),
      .out_valid (rsp_valid),
      .result    (rsp_result)
   );

endmodule
`default_nettype wire

FILE: test/gaussian_field_heat_color_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// gaussian_field_heat_color_tb: self-checking bench for the heat field block
// Sends points through the command port under several register settings,
// predicts level, color and visibility in fixed point, and compares every
// result word in order against the predicted one.
// ---------------------------------------------------------------------------
module gaussian_field_heat_color_tb;

   localparam int  LATENCY   = 27;
   localparam int  MAX_ERR   = 10;
   localparam longint CYCLE_LIMIT = 400000;
   localparam int  VW        = gfhc_pkg::VAL_W;
   localparam int  TAB_DEPTH = gfhc_pkg::EXP_DEPTH;
   // index with no register behind it
   localparam logic [2:0] REG_UNUSED = 3'd7;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   gfhc_pkg::point_type  req_point;
   logic                 rsp_valid;
   gfhc_pkg::result_type rsp_result;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [2:0]           csr_index;
   logic [VW-1:0]        csr_wdata;

   gaussian_field_heat_color dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_point(req_point), .rsp_valid(rsp_valid), .rsp_result(rsp_result),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // predictor copy of the registers
   logic          mode_q;
   logic [VW-1:0] src_x, src_y, src_z, radius_q, gain_q, thresh_q;
   logic [63:0]   falloff_tab [0:TAB_DEPTH];

   gfhc_pkg::point_type  point_queue [$];
   gfhc_pkg::result_type expected_words [$];
   int               mismatches;
   longint           cycle_count;
   logic             idle_enable;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // exp(-16*i/256) table in Q.32, same integer construction as the design
   task automatic build_falloff;
      logic [63:0] term, plus, minus, q;
      term = 64'd1 << 32;
      plus = 64'd1 << 32;
      minus = 64'd0;
      for (int n = 1; n <= 24; n++) begin
         term = term * 64'd16 / (64'd256 * 64'(n));
         if (n % 2 == 1) begin
            minus += term;
         end else begin
            plus += term;
         end
      end
      q = plus - minus;
      falloff_tab[0] = 64'd1 << 32;
      for (int i = 1; i <= TAB_DEPTH; i++) begin
         falloff_tab[i] = (falloff_tab[i-1] * q + (64'd1 << 31)) >> 32;
      end
   endtask

   function automatic logic [63:0] abs_gap(logic [63:0] a, logic [63:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic gfhc_pkg::result_type heat_color(gfhc_pkg::point_type p);
      gfhc_pkg::result_type w;
      logic [63:0] dx, dy, dz, d2, rad, r2, u, pos, idx, fr, t0, t1, e, lvl, s, d, den;
      logic [63:0] r, g, b;
      dx = abs_gap(64'(p.point_x), 64'(src_x));
      dy = abs_gap(64'(p.point_y), 64'(src_y));
      dz = abs_gap(64'(p.point_z), 64'(src_z));
      if (!mode_q) begin
         d2 = dx*dx + dy*dy + dz*dz;
      end else begin
         d2 = dx*dx + (dy*dy) / 5;
      end
      rad = (radius_q < gfhc_pkg::RADIUS_MIN) ? 64'(gfhc_pkg::RADIUS_MIN) : 64'(radius_q);
      r2 = rad * rad;
      u = (d2 << 12) / r2;
      e = 64'd0;
      if (u < 64'd16 * 4096) begin
         pos = u * 256 / 16;
         idx = pos >> 12;
         fr = pos & 64'hFFF;
         if (idx < 256) begin
            t0 = falloff_tab[idx];
            t1 = falloff_tab[idx+1];
            e = t0 - (((t0 - t1) * fr) >> 12);
         end
      end
      lvl = (64'(gain_q) * e + (64'd1 << 31)) >> 32;
      if (lvl > 4096) lvl = 4096;
      s = 100 * lvl;
      if (s < 15 * 4096) begin
         r = 0; g = 0; b = 20 + (400 * lvl) / 4096;
      end else if (s < 45 * 4096) begin
         d = s - 15 * 4096; den = 30 * 4096;
         r = 242 * d / den; g = 51 * d / den; b = 84 - (71 * d + den - 1) / den;
      end else if (s < 75 * 4096) begin
         d = s - 45 * 4096; den = 30 * 4096;
         r = 242; g = 51 + 166 * d / den; b = 13 - (13 * d + den - 1) / den;
      end else begin
         d = s - 75 * 4096; den = 25 * 4096;
         if (d > den) d = den;
         r = 255; g = 217 - (217 * d + den - 1) / den; b = 0;
      end
      w.field_level = VW'(lvl);
      w.red = r[7:0];
      w.green = g[7:0];
      w.blue = b[7:0];
      w.visible = (lvl >= 64'(thresh_q));
      return w;
   endfunction

   // driver: offer the oldest pending point, idle now and then
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (point_queue.size() != 0 &&
                   (!idle_enable || $urandom_range(99) >= 6)) begin
         start <= 1'b1;
         req_point <= point_queue[0];
      end else begin
         start <= 1'b0;
         req_point <= gfhc_pkg::point_type'($urandom);
      end
   end

   // accept: record the prediction when the point is taken
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && start && !busy) begin
         expected_words.insert(expected_words.size(), heat_color(req_point));
         void'(point_queue.pop_front());
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // monitor: compare each result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_words.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < MAX_ERR) $display("unexpected result word %h", rsp_result);
         end else begin
            if (rsp_result !== expected_words[0]) begin
               mismatches <= mismatches + 1;
               if (mismatches < MAX_ERR) begin
                  $display("mismatch: expected lvl %0d rgb %0d %0d %0d vis %0b,",
                     expected_words[0].field_level, expected_words[0].red,
                     expected_words[0].green, expected_words[0].blue,
                     expected_words[0].visible,
                     " got lvl %0d rgb %0d %0d %0d vis %0b",
                     rsp_result.field_level, rsp_result.red,
                     rsp_result.green, rsp_result.blue, rsp_result.visible);
               end
            end
            void'(expected_words.pop_front());
         end
      end
   end

   // write one register through the csr channel and mirror it
   task automatic write_reg(logic [2:0] idx, logic [VW-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         gfhc_pkg::REG_FIELD_MODE:     mode_q = value[0];
         gfhc_pkg::REG_SOURCE_X:       src_x = value;
         gfhc_pkg::REG_SOURCE_Y:       src_y = value;
         gfhc_pkg::REG_SOURCE_Z:       src_z = value;
         gfhc_pkg::REG_FALLOFF_RADIUS: radius_q = value;
         gfhc_pkg::REG_GAIN:           gain_q = value;
         gfhc_pkg::REG_SHOW_THRESHOLD: thresh_q = value;
         default: ;
      endcase
   endtask

   // hold until every queued point is taken and every result is back
   task automatic drain;
      while (point_queue.size() != 0 || expected_words.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [VW-1:0] coord_value();
      case ($urandom_range(9))
         0: return VW'(0);
         1: return VW'(4096);
         2: return VW'($urandom_range(8191, 4097));
         default: return VW'($urandom_range(4096));
      endcase
   endfunction

   task automatic add_point(logic [VW-1:0] x, logic [VW-1:0] y, logic [VW-1:0] z);
      gfhc_pkg::point_type p;
      p.point_x = x;
      p.point_y = y;
      p.point_z = z;
      point_queue.insert(point_queue.size(), p);
   endtask

   // random points, half of them near the source to cover every ramp segment
   task automatic random_points(int count);
      logic [VW-1:0] x, y, z;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(1)) begin
            x = VW'(int'(src_x) + $urandom_range(600) - 300);
            y = VW'(int'(src_y) + $urandom_range(600) - 300);
            z = VW'(int'(src_z) + $urandom_range(600) - 300);
         end else begin
            x = coord_value(); y = coord_value(); z = coord_value();
         end
         add_point(x, y, z);
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_point = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mismatches = 0;
      cycle_count = 0;
      idle_enable = 1'b1;
      mode_q = 1'b0;
      src_x = 13'd2048; src_y = 13'd2048; src_z = 13'd2048;
      radius_q = 13'd1434; gain_q = 13'd4915; thresh_q = 13'd123;
      build_falloff();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes at reset settings
      add_point(13'd2048, 13'd2048, 13'd2048);
      add_point(13'd0, 13'd0, 13'd0);
      add_point(13'd4096, 13'd4096, 13'd4096);
      add_point(13'd8191, 13'd8191, 13'd8191);
      add_point(13'd2200, 13'd2048, 13'd2048);
      add_point(13'd2500, 13'd1900, 13'd2100);
      for (int k = 0; k < 10; k++) add_point(VW'(2048 + 60 * k), 13'd2048, 13'd2048);
      drain();

      // sweep mode, tiny radius saturated, large gain, threshold above one
      write_reg(gfhc_pkg::REG_FIELD_MODE, 13'd1);
      write_reg(gfhc_pkg::REG_FALLOFF_RADIUS, 13'd0);
      write_reg(gfhc_pkg::REG_GAIN, 13'd8191);
      write_reg(gfhc_pkg::REG_SHOW_THRESHOLD, 13'd8191);
      write_reg(REG_UNUSED, 13'h1FFF);
      add_point(13'd2048, 13'd0, 13'd8191);
      add_point(13'd2060, 13'd2100, 13'd0);
      add_point(13'd2100, 13'd2048, 13'd4096);
      add_point(13'd2048, 13'd2300, 13'd0);
      random_points(300);
      drain();

      // each phase: new settings, then a burst of points
      for (int ph = 0; ph < 6; ph++) begin
         idle_enable = (ph != 2);
         write_reg(gfhc_pkg::REG_FIELD_MODE, VW'(ph % 2));
         write_reg(gfhc_pkg::REG_SOURCE_X, (ph == 0) ? 13'd0 : (ph == 1) ? 13'd4096 :
                   VW'($urandom_range(8191)));
         write_reg(gfhc_pkg::REG_SOURCE_Y, (ph == 0) ? 13'd4096 : VW'($urandom_range(4096)));
         write_reg(gfhc_pkg::REG_SOURCE_Z, (ph == 1) ? 13'd0 : VW'($urandom_range(8191)));
         write_reg(gfhc_pkg::REG_FALLOFF_RADIUS, (ph == 0) ? 13'd4096 : (ph == 1) ? 13'd123 :
                   (ph == 5) ? 13'd8191 : VW'($urandom_range(4096, 100)));
         write_reg(gfhc_pkg::REG_GAIN, (ph == 0) ? 13'd6144 : (ph == 1) ? 13'd0 :
                   VW'($urandom_range(8191)));
         write_reg(gfhc_pkg::REG_SHOW_THRESHOLD, (ph == 0) ? 13'd0 : (ph == 1) ? 13'd4096 :
                   VW'($urandom_range(4200)));
         random_points(250);
         drain();
      end

      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
